// File: src/ioag_pkg.sv
// Shared types, constants and width helpers for the image overlay address generator.
// No dependencies; every other file imports this package.
`default_nettype none

package ioag_pkg;

    // Default largest image dimension
    localparam int MAX_DIMENSION_DEF = 4096;

    // Fixed field widths
    localparam int COORD_W    = 13;
    localparam int CFG_DIM_W  = 13;
    localparam int BPP_W      = 3;
    localparam int SEL_W      = 2;
    localparam int SRC_OFS_W  = 27;
    localparam int DST_OFS_W  = 28;
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // Rows are padded to a multiple of this many bytes
    localparam int ROW_ALIGN = 4;
    // Pixel size at or above which four bytes are used
    localparam int BPP_FULL  = 4;

    // Pixel source codes
    typedef enum logic [SEL_W-1:0] {
        SRC_SECOND  = 2'd0,
        SRC_FIRST   = 2'd1,
        SRC_FILL    = 2'd2,
        SRC_OUTSIDE = 2'd3
    } t_src_sel;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_FIRST_WIDTH   = 3'd0,
        REG_FIRST_HEIGHT  = 3'd1,
        REG_SECOND_WIDTH  = 3'd2,
        REG_SECOND_HEIGHT = 3'd3,
        REG_X_SHIFT       = 3'd4,
        REG_Y_SHIFT       = 3'd5,
        REG_BPP           = 3'd6
    } t_reg_idx;

    // Raw register contents
    typedef struct packed {
        logic [CFG_DIM_W-1:0] first_width;
        logic [CFG_DIM_W-1:0] first_height;
        logic [CFG_DIM_W-1:0] second_width;
        logic [CFG_DIM_W-1:0] second_height;
        logic [CFG_DIM_W-1:0] x_shift;
        logic [CFG_DIM_W-1:0] y_shift;
        logic [BPP_W-1:0]     bytes_per_pixel;
    } t_cfg;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Bits to hold a clamped image size
    function automatic int sz_w(input int max_dim);
        return $clog2(max_dim + 1);
    endfunction

endpackage

`default_nettype wire

// File: src/ioag_pix_if.sv
// Request channel carrying one canvas pixel coordinate.
// Depends on ioag_pkg.
`default_nettype none

interface ioag_pix_if import ioag_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] canvas_col;
    logic [COORD_W-1:0] canvas_row;

    modport source (output valid, output canvas_col, output canvas_row, input ready);
    modport sink   (input valid, input canvas_col, input canvas_row, output ready);
endinterface

`default_nettype wire

// File: src/ioag_res_if.sv
// Result channel carrying the source selection and byte offsets of one pixel.
// Depends on ioag_pkg.
`default_nettype none

interface ioag_res_if import ioag_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SEL_W-1:0]     source_select;
    logic [SRC_OFS_W-1:0] source_offset;
    logic [DST_OFS_W-1:0] dest_offset;
    logic [COORD_W-1:0]   canvas_width;
    logic [COORD_W-1:0]   canvas_height;

    modport source (
        output valid, output source_select, output source_offset,
        output dest_offset, output canvas_width, output canvas_height,
        input ready
    );
    modport sink (
        input valid, input source_select, input source_offset,
        input dest_offset, input canvas_width, input canvas_height,
        output ready
    );
endinterface

`default_nettype wire

// File: src/ioag_cfg_regs.sv
// APB register file holding the two image sizes, shifts and pixel size.
// Depends on ioag_pkg.
`default_nettype none

module ioag_cfg_regs import ioag_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; unmapped addresses are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_width     <= CFG_DIM_W'(1);
            r_cfg.first_height    <= CFG_DIM_W'(1);
            r_cfg.second_width    <= CFG_DIM_W'(1);
            r_cfg.second_height   <= CFG_DIM_W'(1);
            r_cfg.x_shift         <= '0;
            r_cfg.y_shift         <= '0;
            r_cfg.bytes_per_pixel <= BPP_W'(3);
        end else if (wr_en) begin
            case (reg_idx)
                REG_FIRST_WIDTH:   r_cfg.first_width     <= pwdata[CFG_DIM_W-1:0];
                REG_FIRST_HEIGHT:  r_cfg.first_height    <= pwdata[CFG_DIM_W-1:0];
                REG_SECOND_WIDTH:  r_cfg.second_width    <= pwdata[CFG_DIM_W-1:0];
                REG_SECOND_HEIGHT: r_cfg.second_height   <= pwdata[CFG_DIM_W-1:0];
                REG_X_SHIFT:       r_cfg.x_shift         <= pwdata[CFG_DIM_W-1:0];
                REG_Y_SHIFT:       r_cfg.y_shift         <= pwdata[CFG_DIM_W-1:0];
                REG_BPP:           r_cfg.bytes_per_pixel <= pwdata[BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_FIRST_WIDTH:   prdata = APB_DATA_W'(r_cfg.first_width);
            REG_FIRST_HEIGHT:  prdata = APB_DATA_W'(r_cfg.first_height);
            REG_SECOND_WIDTH:  prdata = APB_DATA_W'(r_cfg.second_width);
            REG_SECOND_HEIGHT: prdata = APB_DATA_W'(r_cfg.second_height);
            REG_X_SHIFT:       prdata = APB_DATA_W'(r_cfg.x_shift);
            REG_Y_SHIFT:       prdata = APB_DATA_W'(r_cfg.y_shift);
            REG_BPP:           prdata = APB_DATA_W'(r_cfg.bytes_per_pixel);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: src/ioag_geom.sv
// Canvas geometry: clamped sizes, placement, canvas extent and padded row strides.
// Registered once per cycle from the raw registers. Depends on ioag_pkg.
`default_nettype none

module ioag_geom import ioag_pkg::*; #(
    parameter  int MAX_DIMENSION = MAX_DIMENSION_DEF,
    localparam int SZ_W          = sz_w(MAX_DIMENSION),
    localparam int EXT_W         = SZ_W + 1,
    localparam int STR_W         = EXT_W + 2
) (
    input  wire logic             i_clk,
    input  wire t_cfg             i_cfg,
    output logic      [EXT_W-1:0] o_cw,
    output logic      [EXT_W-1:0] o_ch,
    output logic      [SZ_W-1:0]  o_x1,
    output logic      [SZ_W-1:0]  o_y1,
    output logic      [SZ_W-1:0]  o_x2,
    output logic      [SZ_W-1:0]  o_y2,
    output logic      [EXT_W-1:0] o_x1_end,
    output logic      [EXT_W-1:0] o_y1_end,
    output logic      [EXT_W-1:0] o_x2_end,
    output logic      [EXT_W-1:0] o_y2_end,
    output logic      [STR_W-1:0] o_str1,
    output logic      [STR_W-1:0] o_str2,
    output logic      [STR_W-1:0] o_strc,
    output logic                  o_bpp4
);

    // 0 reads as 1, anything above the limit as the limit
    function automatic logic [SZ_W-1:0] clamp_size(input logic [CFG_DIM_W-1:0] v);
        if (v == '0)
            return SZ_W'(1);
        else if (32'(v) > 32'(MAX_DIMENSION))
            return SZ_W'(MAX_DIMENSION);
        else
            return SZ_W'(v);
    endfunction

    // Magnitude of a signed shift, saturated to MAX_DIMENSION - 1
    function automatic logic [SZ_W-1:0] shift_mag(input logic [CFG_DIM_W-1:0] raw);
        logic [CFG_DIM_W-1:0] m;
        m = raw[CFG_DIM_W-1] ? CFG_DIM_W'(-raw) : raw;
        if (32'(m) > 32'(MAX_DIMENSION - 1))
            return SZ_W'(MAX_DIMENSION - 1);
        else
            return SZ_W'(m);
    endfunction

    // Row bytes rounded up to the row alignment
    function automatic logic [STR_W-1:0] row_stride(input logic [EXT_W-1:0] w,
                                                    input logic             bpp4);
        logic [STR_W-1:0] p;
        p = bpp4 ? (STR_W'(w) << 2) : ((STR_W'(w) << 1) + STR_W'(w));
        p = p + STR_W'(ROW_ALIGN - 1);
        return p & ~STR_W'(ROW_ALIGN - 1);
    endfunction

    logic [SZ_W-1:0]  w1, h1, w2, h2, mx, my;
    logic             negx, negy, bpp4;
    logic [SZ_W-1:0]  n_x1, n_x2, n_y1, n_y2;
    logic [EXT_W-1:0] n_x1_end, n_x2_end, n_y1_end, n_y2_end, n_cw, n_ch;

    logic [EXT_W-1:0] r_cw, r_ch, r_x1_end, r_x2_end, r_y1_end, r_y2_end;
    logic [SZ_W-1:0]  r_x1, r_x2, r_y1, r_y2;
    logic [STR_W-1:0] r_str1, r_str2, r_strc;
    logic             r_bpp4;

    assign w1   = clamp_size(i_cfg.first_width);
    assign h1   = clamp_size(i_cfg.first_height);
    assign w2   = clamp_size(i_cfg.second_width);
    assign h2   = clamp_size(i_cfg.second_height);
    assign mx   = shift_mag(i_cfg.x_shift);
    assign my   = shift_mag(i_cfg.y_shift);
    assign negx = i_cfg.x_shift[CFG_DIM_W-1];
    assign negy = i_cfg.y_shift[CFG_DIM_W-1];
    assign bpp4 = 32'(i_cfg.bytes_per_pixel) >= 32'(BPP_FULL);

    // Placement: a negative shift moves the first image instead of the second
    always_comb begin
        n_x1     = negx ? mx : '0;
        n_x2     = negx ? '0 : mx;
        n_y1     = negy ? my : '0;
        n_y2     = negy ? '0 : my;
        n_x1_end = EXT_W'(n_x1) + EXT_W'(w1);
        n_x2_end = EXT_W'(n_x2) + EXT_W'(w2);
        n_y1_end = EXT_W'(n_y1) + EXT_W'(h1);
        n_y2_end = EXT_W'(n_y2) + EXT_W'(h2);
        n_cw     = (n_x1_end >= n_x2_end) ? n_x1_end : n_x2_end;
        n_ch     = (n_y1_end >= n_y2_end) ? n_y1_end : n_y2_end;
    end

    // Geometry register
    always_ff @(posedge i_clk) begin
        r_x1     <= n_x1;
        r_x2     <= n_x2;
        r_y1     <= n_y1;
        r_y2     <= n_y2;
        r_x1_end <= n_x1_end;
        r_x2_end <= n_x2_end;
        r_y1_end <= n_y1_end;
        r_y2_end <= n_y2_end;
        r_cw     <= n_cw;
        r_ch     <= n_ch;
        r_str1   <= row_stride(EXT_W'(w1), bpp4);
        r_str2   <= row_stride(EXT_W'(w2), bpp4);
        r_strc   <= row_stride(n_cw, bpp4);
        r_bpp4   <= bpp4;
    end

    assign o_cw     = r_cw;
    assign o_ch     = r_ch;
    assign o_x1     = r_x1;
    assign o_y1     = r_y1;
    assign o_x2     = r_x2;
    assign o_y2     = r_y2;
    assign o_x1_end = r_x1_end;
    assign o_y1_end = r_y1_end;
    assign o_x2_end = r_x2_end;
    assign o_y2_end = r_y2_end;
    assign o_str1   = r_str1;
    assign o_str2   = r_str2;
    assign o_strc   = r_strc;
    assign o_bpp4   = r_bpp4;

endmodule

`default_nettype wire

// File: src/ioag_addr_calc.sv
// Per-pixel source resolution and byte offset arithmetic (combinational).
// Depends on ioag_pkg.
`default_nettype none

module ioag_addr_calc import ioag_pkg::*; #(
    parameter  int MAX_DIMENSION = MAX_DIMENSION_DEF,
    localparam int SZ_W          = sz_w(MAX_DIMENSION),
    localparam int EXT_W         = SZ_W + 1,
    localparam int STR_W         = EXT_W + 2
) (
    input  wire logic [COORD_W-1:0]   i_col,
    input  wire logic [COORD_W-1:0]   i_row,
    input  wire logic [EXT_W-1:0]     i_cw,
    input  wire logic [EXT_W-1:0]     i_ch,
    input  wire logic [SZ_W-1:0]      i_x1,
    input  wire logic [SZ_W-1:0]      i_y1,
    input  wire logic [SZ_W-1:0]      i_x2,
    input  wire logic [SZ_W-1:0]      i_y2,
    input  wire logic [EXT_W-1:0]     i_x1_end,
    input  wire logic [EXT_W-1:0]     i_y1_end,
    input  wire logic [EXT_W-1:0]     i_x2_end,
    input  wire logic [EXT_W-1:0]     i_y2_end,
    input  wire logic [STR_W-1:0]     i_str1,
    input  wire logic [STR_W-1:0]     i_str2,
    input  wire logic [STR_W-1:0]     i_strc,
    input  wire logic                 i_bpp4,
    output t_src_sel                  o_sel,
    output logic      [SRC_OFS_W-1:0] o_src_ofs,
    output logic      [DST_OFS_W-1:0] o_dst_ofs
);

    localparam int CRD_W = max_int(COORD_W, EXT_W);
    localparam int OFS_W = max_int(CRD_W + STR_W + 1, DST_OFS_W);

    // Column times bytes per pixel as a shift-add
    function automatic logic [OFS_W-1:0] pix_bytes(input logic [CRD_W-1:0] x,
                                                   input logic             bpp4);
        return bpp4 ? (OFS_W'(x) << 2) : ((OFS_W'(x) << 1) + OFS_W'(x));
    endfunction

    logic [CRD_W-1:0] c, r;
    logic             outside, in1, in2;
    logic [SZ_W-1:0]  xs, ys;
    logic [STR_W-1:0] strs;
    logic [SZ_W-1:0]  rel_c, rel_r;
    logic [OFS_W-1:0] src_full, dst_full;

    assign c = CRD_W'(i_col);
    assign r = CRD_W'(i_row);

    // Hit tests against the canvas and both images
    assign outside = (c >= CRD_W'(i_cw)) || (r >= CRD_W'(i_ch));
    assign in2 = (c >= CRD_W'(i_x2)) && (c < CRD_W'(i_x2_end))
              && (r >= CRD_W'(i_y2)) && (r < CRD_W'(i_y2_end));
    assign in1 = (c >= CRD_W'(i_x1)) && (c < CRD_W'(i_x1_end))
              && (r >= CRD_W'(i_y1)) && (r < CRD_W'(i_y1_end));

    // Second image wins on overlap
    always_comb begin
        if (outside)
            o_sel = SRC_OUTSIDE;
        else if (in2)
            o_sel = SRC_SECOND;
        else if (in1)
            o_sel = SRC_FIRST;
        else
            o_sel = SRC_FILL;
    end

    // One shared multiplier for the chosen source image
    assign xs    = in2 ? i_x2 : i_x1;
    assign ys    = in2 ? i_y2 : i_y1;
    assign strs  = in2 ? i_str2 : i_str1;
    assign rel_c = SZ_W'(c - CRD_W'(xs));
    assign rel_r = SZ_W'(r - CRD_W'(ys));

    assign src_full = OFS_W'(rel_r) * OFS_W'(strs) + pix_bytes(CRD_W'(rel_c), i_bpp4);
    assign dst_full = OFS_W'(r) * OFS_W'(i_strc) + pix_bytes(c, i_bpp4);

    assign o_src_ofs = (o_sel == SRC_SECOND || o_sel == SRC_FIRST)
                     ? src_full[SRC_OFS_W-1:0] : '0;
    assign o_dst_ofs = outside ? '0 : dst_full[DST_OFS_W-1:0];

endmodule

`default_nettype wire

// File: src/image_overlay_address_gen_unit.sv
// Image overlay address generator: canvas pixel coordinate in, pixel source and offsets out.
// Requests pass the input register, then the result register, which waits on o_res.ready.
// Throughput: one request per cycle while o_res.ready is high; the result register frees the
// input side while a result waits. Derived geometry is registered the cycle after a write.
// Reset: synchronous, active low; clears both valid bits and loads register reset values.
// Depends on ioag_pkg, ioag_pix_if, ioag_res_if, ioag_cfg_regs, ioag_geom, ioag_addr_calc.
`default_nettype none

module image_overlay_address_gen_unit import ioag_pkg::*; #(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    ioag_pix_if.sink                   i_pix,
    ioag_res_if.source                 o_res
);

    localparam int SZ_W  = sz_w(MAX_DIMENSION);
    localparam int EXT_W = SZ_W + 1;
    localparam int STR_W = EXT_W + 2;

    t_cfg             cfg;
    logic [EXT_W-1:0] geo_cw, geo_ch;
    logic [SZ_W-1:0]  geo_x1, geo_y1, geo_x2, geo_y2;
    logic [EXT_W-1:0] geo_x1_end, geo_y1_end, geo_x2_end, geo_y2_end;
    logic [STR_W-1:0] geo_str1, geo_str2, geo_strc;
    logic             geo_bpp4;

    t_src_sel             calc_sel;
    logic [SRC_OFS_W-1:0] calc_src;
    logic [DST_OFS_W-1:0] calc_dst;

    logic                 r_s1_v, r_s2_v;
    logic [COORD_W-1:0]   r_col, r_row;
    logic [SEL_W-1:0]     r_sel;
    logic [SRC_OFS_W-1:0] r_src;
    logic [DST_OFS_W-1:0] r_dst;
    logic [COORD_W-1:0]   r_cw, r_ch;
    logic                 s2_en, in_take;

    ioag_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ioag_geom #(.MAX_DIMENSION(MAX_DIMENSION)) u_geom (
        .i_clk    (i_clk),
        .i_cfg    (cfg),
        .o_cw     (geo_cw),
        .o_ch     (geo_ch),
        .o_x1     (geo_x1),
        .o_y1     (geo_y1),
        .o_x2     (geo_x2),
        .o_y2     (geo_y2),
        .o_x1_end (geo_x1_end),
        .o_y1_end (geo_y1_end),
        .o_x2_end (geo_x2_end),
        .o_y2_end (geo_y2_end),
        .o_str1   (geo_str1),
        .o_str2   (geo_str2),
        .o_strc   (geo_strc),
        .o_bpp4   (geo_bpp4)
    );

    ioag_addr_calc #(.MAX_DIMENSION(MAX_DIMENSION)) u_addr_calc (
        .i_col     (r_col),
        .i_row     (r_row),
        .i_cw      (geo_cw),
        .i_ch      (geo_ch),
        .i_x1      (geo_x1),
        .i_y1      (geo_y1),
        .i_x2      (geo_x2),
        .i_y2      (geo_y2),
        .i_x1_end  (geo_x1_end),
        .i_y1_end  (geo_y1_end),
        .i_x2_end  (geo_x2_end),
        .i_y2_end  (geo_y2_end),
        .i_str1    (geo_str1),
        .i_str2    (geo_str2),
        .i_strc    (geo_strc),
        .i_bpp4    (geo_bpp4),
        .o_sel     (calc_sel),
        .o_src_ofs (calc_src),
        .o_dst_ofs (calc_dst)
    );

    // Pipeline flow control
    assign s2_en       = !r_s2_v || o_res.ready;
    assign i_pix.ready = !r_s1_v || s2_en;
    assign in_take     = i_pix.valid && i_pix.ready;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (i_pix.ready)
                r_s1_v <= i_pix.valid;
            if (s2_en)
                r_s2_v <= r_s1_v;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_col <= i_pix.canvas_col;
            r_row <= i_pix.canvas_row;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (s2_en && r_s1_v) begin
            r_sel <= calc_sel;
            r_src <= calc_src;
            r_dst <= calc_dst;
            r_cw  <= COORD_W'(geo_cw);
            r_ch  <= COORD_W'(geo_ch);
        end
    end

    assign o_res.valid         = r_s2_v;
    assign o_res.source_select = r_sel;
    assign o_res.source_offset = r_src;
    assign o_res.dest_offset   = r_dst;
    assign o_res.canvas_width  = r_cw;
    assign o_res.canvas_height = r_ch;

endmodule

`default_nettype wire
